// File: rtl/sbce_pkg.sv
// ---------------------------------------------------------------------------
// sbce_pkg
// types and constants shared by the stereo biquad cascade equalizer
// ---------------------------------------------------------------------------
`default_nettype none
package sbce_pkg;
  localparam logic [1:0] CMD_PROCESS = 2'd0;
  localparam logic [1:0] CMD_COEF    = 2'd1;
  localparam logic [1:0] CMD_CLEAR   = 2'd2;

  localparam logic [1:0] REG_BAND_ENABLE = 2'd0;
  localparam logic [1:0] REG_OUTPUT_GAIN = 2'd1;
  localparam logic [1:0] REG_WET_MIX     = 2'd2;

  localparam logic [2:0] SLOT_B0 = 3'd0;
  localparam logic [2:0] SLOT_A2 = 3'd4;

  localparam int MIX_BYPASS = 6;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [23:0] left_in;
    logic signed [23:0] right_in;
    logic               mono_flag;
    logic [2:0]         band_select;
    logic [2:0]         coef_select;
    logic signed [31:0] coef_value;
    logic               block_last;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] left_out;
    logic signed [23:0] right_out;
    logic               block_end;
  } out_item_t;

  // saturating signed add on 64 bits
  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (!a[63] && !b[63] && s[63]) sat_add64 = {1'b0, {63{1'b1}}};
    else if (a[63] && b[63] && !s[63]) sat_add64 = {1'b1, 63'd0};
    else sat_add64 = s;
  endfunction
endpackage
`default_nettype wire

// File: rtl/stereo_biquad_cascade_equalizer_unit.sv
// ---------------------------------------------------------------------------
// stereo_biquad_cascade_equalizer_unit
// stereo eight-band direct-form-I equalizer with output gain and dry/wet mix
// ---------------------------------------------------------------------------
// One shared multiply-accumulate unit walks the coefficient and history
// memories one word a cycle, so time is set by the enabled bands. Per channel
// an enabled band passes through the band decision, the five products and
// rounding, and history write back, and a disabled band through the band
// decision alone, followed by the final band check, gain and mix; the unit is
// ready for the next request in the same cycle that a process result is
// offered. Results sit in an output register, so a stalled result only holds
// back the final S_DONE step of the following sample. A coefficient write is
// done as the request is accepted. A clear request sweeps the history memory
// one entry a cycle (all 64 entries with eight bands) and the next request is
// taken in the cycle after the sweep ends. After reset one sweep clears the
// history memory and loads the coefficient memory before the first request is
// taken. Bypassed samples skip the band, gain and mix states and go straight
// to the result step.
`default_nettype none
module stereo_biquad_cascade_equalizer_unit #(
  parameter int NUM_BANDS = 8
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  sbce_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output sbce_pkg::out_item_t out_data,
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire  [1:0]          cfg_index,
  input  wire  [31:0]         cfg_data
);
  localparam int HD = 2 * NUM_BANDS * 4;
  localparam int CD = NUM_BANDS * 5;
  localparam int HAW = $clog2(HD);
  localparam int CAW = $clog2(CD);
  localparam int BW = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;

  typedef enum logic [9:0] {
    S_INIT  = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_CLR   = 10'b0000000100,
    S_BAND  = 10'b0000001000,
    S_MAC   = 10'b0000010000,
    S_WB    = 10'b0000100000,
    S_GAIN  = 10'b0001000000,
    S_MIX   = 10'b0010000000,
    S_MIX2  = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  state_t state_r;
  logic [7:0]  band_en_r;
  logic [15:0] gain_r;
  logic [16:0] mix_r;

  // memories
  logic signed [31:0] hmem [HD];
  logic signed [31:0] cmem [CD];
  logic signed [31:0] hrd_r, crd_r;
  logic [HAW-1:0] hra, hwa;
  logic [CAW-1:0] cra, cwa;
  logic hwe, cwe;
  logic signed [31:0] hwd, cwd;

  always_ff @(posedge clk) begin
    if (hwe) hmem[hwa] <= hwd;
    if (cwe) cmem[cwa] <= cwd;
    hrd_r <= hmem[hra];
    crd_r <= cmem[cra];
  end

  logic [HAW:0] clr_r;
  logic cinit_r;
  sbce_pkg::in_item_t item_r;
  logic ch_r;
  logic [BW:0] band_r;
  logic [3:0] step_r;
  logic signed [63:0] acc_r;
  logic signed [31:0] x_r, y_r, dry_r;
  logic signed [31:0] h_r [4];
  logic signed [63:0] prod_r;
  logic prod_v_r, prod_neg_r;
  logic signed [23:0] ol_r, or_r;
  logic signed [31:0] gx_r;
  logic signed [63:0] mixa_r;
  sbce_pkg::out_item_t out_r;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  // result register frees up when empty or taken this cycle
  wire load_out = (state_r == S_DONE) && (!out_valid || out_ready);

  wire [16:0] mix_c = (mix_r > 17'd65536) ? 17'd65536 : mix_r;
  wire bypass = mix_c <= 17'(sbce_pkg::MIX_BYPASS);

  function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
    if (v > 64'sd8388607) sat24 = 24'sh7fffff;
    else if (v < -64'sd8388608) sat24 = 24'sh800000;
    else sat24 = v[23:0];
  endfunction
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) sat32 = 32'sh7fffffff;
    else if (v < -64'sd2147483648) sat32 = 32'sh80000000;
    else sat32 = v[31:0];
  endfunction

  // address helpers
  wire [BW-1:0] bidx = band_r[BW-1:0];
  wire [HAW-1:0] hbase = HAW'((32'(ch_r) * NUM_BANDS + 32'(bidx)) * 4);
  wire [CAW-1:0] cbase = CAW'(32'(bidx) * 5);

  // rounded shift by 26 with saturating bias
  wire signed [63:0] acc_bias = sbce_pkg::sat_add64(acc_r, 64'sd1 <<< 25);
  wire signed [63:0] acc_sh = acc_bias >>> 26;
  logic signed [63:0] addend;
  always_comb begin
    if (prod_neg_r) addend = (prod_r == {1'b1, 63'd0}) ? {1'b0, {63{1'b1}}} : -prod_r;
    else addend = prod_r;
  end

  always_comb begin
    hwe = 1'b0; hwa = hbase; hwd = '0;
    cwe = 1'b0; cwa = cbase; cwd = '0;
    hra = hbase; cra = cbase;
    if (state_r == S_INIT || state_r == S_CLR) begin
      hwe = 1'b1; hwa = clr_r[HAW-1:0];
      if (state_r == S_INIT && cinit_r && clr_r < (HAW+1)'(CD)) begin
        // step_r tracks the slot within the band during the init sweep
        cwe = 1'b1; cwa = CAW'(clr_r);
        cwd = (step_r == 4'(sbce_pkg::SLOT_B0)) ? 32'sd1 <<< 26 : 32'sd0;
      end
    end else if (state_r == S_IDLE && in_valid && in_ready &&
                 in_data.command == sbce_pkg::CMD_COEF &&
                 32'(in_data.band_select) < NUM_BANDS &&
                 in_data.coef_select <= sbce_pkg::SLOT_A2) begin
      cwe = 1'b1;
      cwa = CAW'(32'(in_data.band_select) * 5 + 32'(in_data.coef_select));
      cwd = in_data.coef_value;
    end else if (state_r == S_MAC) begin
      cra = cbase + CAW'(step_r);
      hra = hbase + HAW'(step_r - 4'd1);
    end else if (state_r == S_WB) begin
      hwe = 1'b1;
      case (step_r)
        4'd0: begin hwa = hbase;           hwd = x_r; end
        4'd1: begin hwa = hbase + HAW'(1); hwd = h_r[0]; end
        4'd2: begin hwa = hbase + HAW'(2); hwd = y_r; end
        default: begin hwa = hbase + HAW'(3); hwd = h_r[2]; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT; clr_r <= '0; cinit_r <= 1'b1; step_r <= '0;
      band_en_r <= 8'd0; gain_r <= 16'd4096; mix_r <= 17'd65536;
      out_valid <= 1'b0; prod_v_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          sbce_pkg::REG_BAND_ENABLE: band_en_r <= cfg_data[7:0];
          sbce_pkg::REG_OUTPUT_GAIN: gain_r <= cfg_data[15:0];
          sbce_pkg::REG_WET_MIX:     mix_r <= cfg_data[16:0];
          default: ;
        endcase
      end
      if (load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      prod_v_r <= 1'b0;
      case (state_r)
        S_INIT, S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (state_r == S_INIT)
            step_r <= (step_r == 4'(sbce_pkg::SLOT_A2)) ? '0 : step_r + 1'b1;
          if (clr_r == (HAW+1)'(HD-1)) begin
            state_r <= S_IDLE; cinit_r <= 1'b0;
          end
        end
        S_IDLE: if (in_valid && in_ready) begin
          item_r <= in_data;
          if (in_data.command == sbce_pkg::CMD_CLEAR) begin
            clr_r <= '0; state_r <= S_CLR;
          end else if (in_data.command == sbce_pkg::CMD_PROCESS) begin
            if (bypass) begin
              ol_r <= in_data.left_in;
              or_r <= in_data.mono_flag ? in_data.left_in : in_data.right_in;
              state_r <= S_DONE;
            end else begin
              ch_r <= 1'b0; band_r <= '0;
              x_r <= 32'(in_data.left_in); dry_r <= 32'(in_data.left_in);
              state_r <= S_BAND;
            end
          end
        end
        S_BAND: begin
          if (band_r == (BW+1)'(NUM_BANDS)) begin
            state_r <= S_GAIN; step_r <= '0;
          end else if (band_en_r[bidx]) begin
            state_r <= S_MAC; step_r <= '0; acc_r <= '0;
          end else band_r <= band_r + 1'b1;
        end
        S_MAC: begin
          // reads issued at steps 0..4, products at 1..5, acc at 2..6
          step_r <= step_r + 1'b1;
          if (step_r >= 4'd2 && step_r <= 4'd5) h_r[2'(step_r - 4'd2)] <= hrd_r;
          if (step_r >= 4'd1 && step_r <= 4'd5) begin
            prod_r <= crd_r * ((step_r == 4'd1) ? x_r : hrd_r);
            prod_neg_r <= (step_r >= 4'd4);
            prod_v_r <= 1'b1;
          end
          if (prod_v_r) acc_r <= sbce_pkg::sat_add64(acc_r, addend);
          if (step_r == 4'd7) begin
            y_r <= sat32(acc_sh);
            state_r <= S_WB; step_r <= '0;
          end
        end
        S_WB: begin
          step_r <= step_r + 1'b1;
          if (step_r == 4'd3) begin
            x_r <= y_r; band_r <= band_r + 1'b1; state_r <= S_BAND;
          end
        end
        S_GAIN: begin
          step_r <= step_r + 1'b1;
          if (step_r == 4'd0) prod_r <= x_r * $signed({1'b0, gain_r});
          else begin
            gx_r <= sat32((prod_r + 64'sd2048) >>> 12);
            step_r <= '0; state_r <= S_MIX;
          end
        end
        S_MIX: begin
          step_r <= step_r + 1'b1;
          if (step_r == 4'd0) prod_r <= dry_r * $signed({15'd0, 17'd65536 - mix_c});
          else if (step_r == 4'd1) begin
            mixa_r <= prod_r; prod_r <= gx_r * $signed({15'd0, mix_c});
          end else state_r <= S_MIX2;
        end
        S_MIX2: begin
          if (!ch_r) begin
            ol_r <= sat24((mixa_r + prod_r + 64'sd32768) >>> 16);
            ch_r <= 1'b1; band_r <= '0;
            x_r <= item_r.mono_flag ? 32'(item_r.left_in) : 32'(item_r.right_in);
            dry_r <= item_r.mono_flag ? 32'(item_r.left_in) : 32'(item_r.right_in);
            state_r <= S_BAND;
          end else begin
            or_r <= sat24((mixa_r + prod_r + 64'sd32768) >>> 16);
            state_r <= S_DONE;
          end
        end
        S_DONE: if (load_out) begin
          out_r <= '{left_out: ol_r, right_out: or_r, block_end: item_r.block_last};
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_data = out_r;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> state_r == S_IDLE) else $error("accept while busy");
  a_out_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r) == S_DONE) else $error("stray result");
  a_wb_band: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MAC |-> band_r < (BW+1)'(NUM_BANDS)) else $error("band out of range");
endmodule
`default_nettype wire

// File: test/stereo_biquad_cascade_equalizer_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stereo_biquad_cascade_equalizer_checker
// watches the request, result and register channels of the equalizer, keeps
// its own model of coefficients, history and registers, and compares every
// result against the oldest predicted sample pair
// ---------------------------------------------------------------------------
module stereo_biquad_cascade_equalizer_checker (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  input  wire                 in_ready,
  input  sbce_pkg::in_item_t  in_data,
  input  wire                 out_valid,
  input  wire                 out_ready,
  input  sbce_pkg::out_item_t out_data,
  input  wire                 cfg_valid,
  input  wire                 cfg_ready,
  input  wire  [1:0]          cfg_index,
  input  wire  [31:0]         cfg_data,
  output int                  fail_count,
  output int                  pending
);
  localparam int BANDS = 8;
  localparam longint S64_MAX = 64'sh7fff_ffff_ffff_ffff;
  localparam longint S64_MIN = 64'sh8000_0000_0000_0000;

  longint     hist [2][BANDS][4];  // x1 x2 y1 y2
  longint     coefs[BANDS][5];
  logic [7:0]  band_on;
  logic [15:0] gain_q12;
  logic [16:0] mix_q16;
  sbce_pkg::out_item_t expected_pairs[$];

  function automatic longint add_sat(longint a, longint b);
    longint s;
    s = a + b;
    if (a >= 0 && b >= 0 && s < 0) return S64_MAX;
    if (a < 0 && b < 0 && s >= 0) return S64_MIN;
    return s;
  endfunction

  // round to nearest, ties up
  function automatic longint round_down(longint v, int k);
    longint t;
    t = add_sat(v, 64'sd1 <<< (k - 1));
    return t >>> k;
  endfunction

  function automatic longint clamp(longint v, int bits);
    longint hi, lo;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    lo = -hi - 1;
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  // products are at most 2^62 in size, so only the sum can overflow
  function automatic longint run_biquad(longint x, int ch, int b);
    longint acc, y;
    acc = coefs[b][0] * x;
    acc = add_sat(acc, coefs[b][1] * hist[ch][b][0]);
    acc = add_sat(acc, coefs[b][2] * hist[ch][b][1]);
    acc = add_sat(acc, -(coefs[b][3] * hist[ch][b][2]));
    acc = add_sat(acc, -(coefs[b][4] * hist[ch][b][3]));
    y = clamp(round_down(acc, 26), 32);
    hist[ch][b][1] = hist[ch][b][0];
    hist[ch][b][0] = x;
    hist[ch][b][3] = hist[ch][b][2];
    hist[ch][b][2] = y;
    return y;
  endfunction

  function automatic longint equalize(longint dry, int ch, longint m);
    longint x;
    x = dry;
    for (int b = 0; b < BANDS; b++)
      if (band_on[b]) x = run_biquad(x, ch, b);
    x = clamp(round_down(x * longint'(gain_q12), 12), 32);
    return clamp(round_down(dry * (65536 - m) + x * m, 16), 24);
  endfunction

  function automatic void clear_history();
    foreach (hist[c, b, k]) hist[c][b][k] = 0;
  endfunction

  function automatic sbce_pkg::out_item_t predict_pair(sbce_pkg::in_item_t it);
    sbce_pkg::out_item_t r;
    longint l, rt, m;
    l  = longint'(it.left_in);
    rt = it.mono_flag ? l : longint'(it.right_in);
    m  = mix_q16 > 17'd65536 ? 65536 : longint'(mix_q16);
    if (m > sbce_pkg::MIX_BYPASS) begin
      l  = equalize(l, 0, m);
      rt = equalize(rt, 1, m);
    end
    r.left_out  = l[23:0];
    r.right_out = rt[23:0];
    r.block_end = it.block_last;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_history();
      foreach (coefs[b, k]) coefs[b][k] = (k == 0) ? (64'sd1 <<< 26) : 0;
      band_on  = 8'd0;
      gain_q12 = 16'd4096;
      mix_q16  = 17'd65536;
      expected_pairs.delete();
      fail_count = 0;
      pending    = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          sbce_pkg::REG_BAND_ENABLE: band_on  = cfg_data[7:0];
          sbce_pkg::REG_OUTPUT_GAIN: gain_q12 = cfg_data[15:0];
          sbce_pkg::REG_WET_MIX:     mix_q16  = cfg_data[16:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        case (in_data.command)
          sbce_pkg::CMD_PROCESS: expected_pairs.push_back(predict_pair(in_data));
          sbce_pkg::CMD_COEF: begin
            if (in_data.coef_select <= sbce_pkg::SLOT_A2)
              coefs[in_data.band_select][in_data.coef_select] =
                longint'(in_data.coef_value);
          end
          sbce_pkg::CMD_CLEAR: clear_history();
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_pairs.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: unexpected result %h at %0t", out_data, $realtime);
        end else begin
          sbce_pkg::out_item_t e;
          e = expected_pairs.pop_front();
          if (e !== out_data) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch at %0t: exp L=%0d R=%0d end=%0b got L=%0d R=%0d end=%0b",
                       $realtime, e.left_out, e.right_out, e.block_end,
                       out_data.left_out, out_data.right_out, out_data.block_end);
          end
        end
      end
      pending = expected_pairs.size();
    end
  end
endmodule

// File: test/stereo_biquad_cascade_equalizer_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stereo_biquad_cascade_equalizer_unit_tb
// drives directed and random requests, coefficient writes and register
// settings into the equalizer under random back pressure; a checker beside
// the block predicts every output pair
// ---------------------------------------------------------------------------
module stereo_biquad_cascade_equalizer_unit_tb;
  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  sbce_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  sbce_pkg::out_item_t out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [1:0]          cfg_index = '0;
  logic [31:0]         cfg_data = '0;
  int                  fail_count;
  int                  pending;
  bit                  quiet = 1'b0;
  int                  stall_left = 0;

  always #5 clk = ~clk;

  stereo_biquad_cascade_equalizer_unit dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
    .out_data, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  stereo_biquad_cascade_equalizer_checker checker_i (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
    .out_data, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .fail_count, .pending
  );

  // result side back pressure
  always @(posedge clk) begin
    if (quiet) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 12);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // valid stays high from one request to the next unless a gap is inserted
  task automatic send_request(sbce_pkg::in_item_t it);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_regs(logic [7:0] bands, logic [15:0] gain, logic [16:0] mix);
    logic [31:0] noise;
    noise = $urandom();
    write_reg(sbce_pkg::REG_BAND_ENABLE, {noise[31:8], bands});
    write_reg(sbce_pkg::REG_OUTPUT_GAIN, {noise[31:16], gain});
    write_reg(sbce_pkg::REG_WET_MIX, {noise[31:17], mix});
    if ($urandom_range(0, 3) == 0) write_reg(2'd3, noise);
    cfg_valid <= 1'b0;
  endtask

  // random fill for the fields a request does not use
  function automatic sbce_pkg::in_item_t rand_item();
    logic [95:0] raw;
    raw = {$urandom(), $urandom(), $urandom()};
    return raw[$bits(sbce_pkg::in_item_t)-1:0];
  endfunction

  function automatic sbce_pkg::in_item_t sample_pair(int sl, int sr, bit mono, bit last);
    sbce_pkg::in_item_t it;
    it = rand_item();
    it.command   = sbce_pkg::CMD_PROCESS;
    it.left_in   = 24'(sl);
    it.right_in  = 24'(sr);
    it.mono_flag = mono;
    it.block_last = last;
    return it;
  endfunction

  function automatic sbce_pkg::in_item_t coef_write(int band, int slot, int val);
    sbce_pkg::in_item_t it;
    it = rand_item();
    it.command     = sbce_pkg::CMD_COEF;
    it.band_select = 3'(band);
    it.coef_select = 3'(slot);
    it.coef_value  = val;
    return it;
  endfunction

  function automatic int tame_coef(int slot);
    if ($urandom_range(0, 9) == 0) return $urandom();
    if (slot == sbce_pkg::SLOT_B0)
      return (1 << 26) + $signed($urandom_range(0, 1 << 25)) - (1 << 24);
    return $signed($urandom_range(0, 1 << 25)) - (1 << 24);
  endfunction

  function automatic int rand_sample();
    case ($urandom_range(0, 3))
      0:       return $signed($urandom()) >>> 8;
      1:       return $signed($urandom_range(0, 2000)) - 1000;
      2:       return $urandom_range(0, 1) ? 8388607 : -8388608;
      default: return $signed($urandom()) >>> 12;
    endcase
  endfunction

  function automatic sbce_pkg::in_item_t rand_request();
    sbce_pkg::in_item_t it;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 78) begin
      it = sample_pair(rand_sample(), rand_sample(), $urandom_range(0, 3) == 0,
                       $urandom_range(0, 1) == 1);
    end else if (pick < 94) begin
      it = coef_write($urandom_range(0, 7), $urandom_range(0, 5), 0);
      it.coef_value = tame_coef(it.coef_select);
    end else if (pick < 97) begin
      it = rand_item();
      it.command = sbce_pkg::CMD_CLEAR;
    end else begin
      it = rand_item();
      it.command = 2'd3;
    end
    return it;
  endfunction

  initial begin
    logic [16:0] mixes[6];
    sbce_pkg::in_item_t it;
    mixes = '{17'd0, 17'd6, 17'd7, 17'd65536, 17'd131071, 17'd32768};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset coefficients pass straight through
    send_request(sample_pair(8388607, -8388608, 1'b0, 1'b1));
    send_request(sample_pair(-8388608, 123, 1'b1, 1'b0));
    wait_idle();
    set_regs(8'hff, 16'hffff, 17'd65536);
    send_request(sample_pair(8388607, -8388608, 1'b0, 1'b0));
    send_request(coef_write(0, sbce_pkg::SLOT_B0, 32'h7fff_ffff));
    send_request(coef_write(7, sbce_pkg::SLOT_A2, 32'h8000_0000));
    send_request(coef_write(3, 5, 32'h1234_5678));   // bad slot, ignored
    send_request(coef_write(2, 7, 32'hffff_ffff));   // bad slot, ignored
    send_request(coef_write(1, 1, 32'h0400_0000));
    send_request(coef_write(1, 3, 32'hfc00_0000));
    send_request(sample_pair(8388607, 8388607, 1'b0, 1'b1));
    send_request(sample_pair(-8388608, -1, 1'b1, 1'b0));
    send_request(sample_pair(0, 8388607, 1'b0, 1'b1));
    it = rand_request();
    it.command = sbce_pkg::CMD_CLEAR;
    send_request(it);
    it.command = 2'd3;
    send_request(it);
    send_request(sample_pair(-8388608, 8388607, 1'b0, 1'b0));
    wait_idle();
    set_regs(8'h00, 16'd0, 17'd6);
    send_request(sample_pair(8388607, -8388608, 1'b0, 1'b1));
    wait_idle();
    set_regs(8'h00, 16'hffff, 17'd7);
    send_request(sample_pair(8388607, -8388608, 1'b0, 1'b1));
    send_request(sample_pair(-5, 5, 1'b1, 1'b0));
    wait_idle();
    set_regs(8'h00, 16'd4096, 17'd131071);
    send_request(sample_pair(-8388608, 8388607, 1'b0, 1'b0));
    wait_idle();
    // restore tame coefficients before the random part
    for (int b = 0; b < 8; b++)
      for (int s = 0; s <= sbce_pkg::SLOT_A2; s++)
        send_request(coef_write(b, s, s == sbce_pkg::SLOT_B0 ? (1 << 26) : 0));

    for (int ph = 0; ph < 16; ph++) begin
      wait_idle();
      quiet = (ph >= 14);
      if (ph < 6)
        set_regs(8'($urandom()), $urandom_range(0, 1) ? 16'd4096 : 16'($urandom()),
                 mixes[ph]);
      else
        set_regs(8'($urandom()), 16'($urandom_range(0, 8192)),
                 17'($urandom_range(0, 70000)));
      for (int i = 0; i < 100; i++) send_request(rand_request());
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end
endmodule
